### rtl/hpbt_pkg.sv
// Shared types and constants for the header block tokenizer.
// Used by hpbt_step and hpack_header_block_tokenizer_top; depends on nothing.
`default_nettype none

package hpbt_pkg;

    typedef enum logic [2:0] {
        ST_IDX     = 3'd0,
        ST_KEY_LEN = 3'd1,
        ST_VAL_LEN = 3'd2,
        ST_KEY     = 3'd3,
        ST_VAL     = 3'd4
    } parse_state_t;

    // Element kinds reported with every byte.
    localparam logic [2:0] KIND_INT_PART = 3'd0;
    localparam logic [2:0] KIND_INDEX    = 3'd1;
    localparam logic [2:0] KIND_KEY_LEN  = 3'd2;
    localparam logic [2:0] KIND_KEY_BYTE = 3'd3;
    localparam logic [2:0] KIND_VAL_LEN  = 3'd4;
    localparam logic [2:0] KIND_VAL_BYTE = 3'd5;

    localparam logic [2:0] PREFIX_NONE   = 3'd0;
    localparam logic [2:0] PREFIX_STRLEN = 3'd7;
    localparam logic [5:0] SHIFT_STEP    = 6'd7;
    localparam logic [5:0] SHIFT_LIMIT   = 6'd56;
    localparam logic [5:0] SHIFT_MAX     = 6'd63;

    typedef struct packed {
        parse_state_t parse_state;
        logic [2:0]   prefix_bits;
        logic [5:0]   shift_count;
        logic         int_continues;
        logic         int_sat;
        logic [1:0]   rep_kind;
    } ctrl_t;

    typedef struct packed {
        logic       int_overflow;
        logic       string_last;
        logic [1:0] representation;
        logic [2:0] element_kind;
    } result_t;

    localparam ctrl_t CTRL_RESET = '{
        parse_state:   ST_IDX,
        prefix_bits:   PREFIX_NONE,
        shift_count:   6'd0,
        int_continues: 1'b0,
        int_sat:       1'b0,
        rep_kind:      2'd0
    };

    // Prefix width of a field's first byte, picked from its top nibble.
    function automatic logic [2:0] prefix_of_nibble(input logic [3:0] nibble);
        logic [2:0] width;
        case (nibble) inside
            [4'd0:4'd1]:  width = 3'd4;
            [4'd2:4'd3]:  width = 3'd5;
            [4'd4:4'd7]:  width = 3'd6;
            default:      width = 3'd7;
        endcase
        return width;
    endfunction

endpackage

`default_nettype wire

### rtl/hpbt_step.sv
// Combinational next-state and result logic for one header block byte.
// Depends on hpbt_pkg; instantiated by hpack_header_block_tokenizer_top.
`default_nettype none

module hpbt_step
    import hpbt_pkg::*;
#(
    parameter int INT_BITS = 32
) (
    input  wire logic [7:0]          data_byte,
    input  wire ctrl_t               ctrl_cur,
    input  wire logic [INT_BITS-1:0] accum_cur,
    input  wire logic [INT_BITS-1:0] remaining_cur,
    output ctrl_t                    ctrl_next,
    output logic [INT_BITS-1:0]      accum_next,
    output logic [INT_BITS-1:0]      remaining_next,
    output result_t                  result,
    output logic [INT_BITS-1:0]      int_value
);

    localparam int SUM_W = INT_BITS + 8;
    localparam logic [INT_BITS-1:0] SAT_MAX = '1;

    logic [6:0]          chunk;
    logic                shift_ok;
    logic [SUM_W-1:0]    shifted;
    logic [SUM_W-1:0]    sum;
    logic                add_ovf;
    logic                sat_new;
    logic [INT_BITS-1:0] rem_dec;
    logic                wide;
    logic [6:0]          mask;
    logic [INT_BITS-1:0] masked;

    function automatic logic [2:0] done_kind(input parse_state_t st);
        logic [2:0] k;
        case (st)
            ST_KEY_LEN: k = KIND_KEY_LEN;
            ST_VAL_LEN: k = KIND_VAL_LEN;
            default:    k = KIND_INDEX;
        endcase
        return k;
    endfunction

    function automatic logic [INT_BITS-1:0] rem_dec_of(input logic [INT_BITS-1:0] len);
        return len - INT_BITS'(1);
    endfunction

    assign chunk    = data_byte[6:0];
    assign shift_ok = {1'b0, ctrl_cur.shift_count} < 7'(INT_BITS);
    assign shifted  = SUM_W'(chunk) << ctrl_cur.shift_count;
    assign sum      = SUM_W'(accum_cur) + shifted;
    assign add_ovf  = sum[SUM_W-1:INT_BITS] != '0;
    assign sat_new  = ctrl_cur.int_sat || ((chunk != 7'd0) && (!shift_ok || add_ovf));
    assign rem_dec  = remaining_cur - INT_BITS'(1);
    assign wide     = (ctrl_cur.prefix_bits == 3'd6) || (ctrl_cur.prefix_bits == 3'd4);

    always_comb
    begin
        ctrl_next      = ctrl_cur;
        accum_next     = accum_cur;
        remaining_next = remaining_cur;
        result.element_kind = KIND_INT_PART;
        result.string_last  = 1'b0;
        result.int_overflow = 1'b0;
        int_value      = '0;
        mask           = 7'd0;
        masked         = '0;

        if (((ctrl_cur.parse_state == ST_KEY) || (ctrl_cur.parse_state == ST_VAL))
            && (remaining_cur != '0))
        begin
            remaining_next      = rem_dec;
            result.element_kind = (ctrl_cur.parse_state == ST_KEY) ? KIND_KEY_BYTE
                                                                   : KIND_VAL_BYTE;
            result.string_last  = (rem_dec == '0);
        end
        else if (((ctrl_cur.parse_state == ST_IDX) || (ctrl_cur.parse_state == ST_KEY_LEN)
                  || (ctrl_cur.parse_state == ST_VAL_LEN)) && ctrl_cur.int_continues)
        begin
            // Continuation byte: seven more bits, saturating at the integer maximum.
            ctrl_next.int_sat = sat_new;
            if (sat_new)
            begin
                accum_next = SAT_MAX;
            end
            else if (chunk != 7'd0)
            begin
                accum_next = sum[INT_BITS-1:0];
            end
            ctrl_next.shift_count   = (ctrl_cur.shift_count > SHIFT_LIMIT) ? SHIFT_MAX
                                    : ctrl_cur.shift_count + SHIFT_STEP;
            ctrl_next.int_continues = data_byte[7];
            result.int_overflow     = sat_new;
            if (!data_byte[7])
            begin
                result.element_kind = done_kind(ctrl_cur.parse_state);
                int_value           = accum_next;
            end
        end
        else
        begin
            ctrl_next.shift_count   = 6'd0;
            ctrl_next.int_continues = 1'b0;
            ctrl_next.int_sat       = 1'b0;
            if (((ctrl_cur.parse_state == ST_KEY_LEN) || (ctrl_cur.parse_state == ST_VAL_LEN))
                && (accum_cur != '0))
            begin
                // First byte of a non-empty string.
                ctrl_next.parse_state = (ctrl_cur.parse_state == ST_KEY_LEN) ? ST_KEY : ST_VAL;
                ctrl_next.prefix_bits = PREFIX_NONE;
                accum_next            = '0;
                remaining_next        = rem_dec_of(accum_cur);
                result.element_kind   = (ctrl_cur.parse_state == ST_KEY_LEN) ? KIND_KEY_BYTE
                                                                             : KIND_VAL_BYTE;
                result.string_last    = (accum_cur == INT_BITS'(1));
            end
            else
            begin
                // An empty key, the end of a key, or a literal (with an indexed or a new name)
                // all move on to a length; anything else opens a new field.
                if ((ctrl_cur.parse_state == ST_KEY_LEN)
                    || ((ctrl_cur.parse_state == ST_IDX) && wide && (accum_cur != '0))
                    || (ctrl_cur.parse_state == ST_KEY))
                begin
                    ctrl_next.parse_state = ST_VAL_LEN;
                    ctrl_next.prefix_bits = PREFIX_STRLEN;
                end
                else if ((ctrl_cur.parse_state == ST_IDX) && wide)
                begin
                    ctrl_next.parse_state = ST_KEY_LEN;
                    ctrl_next.prefix_bits = PREFIX_STRLEN;
                end
                else
                begin
                    ctrl_next.parse_state = ST_IDX;
                    ctrl_next.prefix_bits = prefix_of_nibble(data_byte[7:4]);
                    ctrl_next.rep_kind    = 2'(3'd7 - ctrl_next.prefix_bits);
                end
                mask                    = 7'h7f >> (3'd7 - ctrl_next.prefix_bits);
                masked                  = INT_BITS'(data_byte[6:0] & mask);
                accum_next              = masked;
                remaining_next          = '0;
                ctrl_next.int_continues = (data_byte[6:0] & mask) == mask;
                if ((data_byte[6:0] & mask) != mask)
                begin
                    result.element_kind = done_kind(ctrl_next.parse_state);
                    int_value           = masked;
                end
            end
        end

        result.representation = ctrl_next.rep_kind;
    end

endmodule

`default_nettype wire

### rtl/hpack_header_block_tokenizer_top.sv
// Header block tokenizer: one byte in, one classified element out.
// Depends on hpbt_pkg and hpbt_step.
//
// Usage:
//   Input stream s_*: s_tdata[7:0] is one header block byte, s_tuser[0] is the
//   block-start flag that clears all parse state before that byte is handled.
//   Output stream m_*: one transaction per input byte. m_tdata carries the
//   decoded integer (zero unless an index or length just finished), m_tuser
//   carries the element kind, the representation and the overflow flag, and
//   m_tlast marks the final byte of a key or value string.
// Timing:
//   A byte is registered in the input register on acceptance, and its result is
//   then registered in the output register, from which it is offered. The
//   per-byte work is a shift-add with a saturation compare, so one byte is
//   taken every cycle while the output is drained.
// Reset and stalls:
//   Reset empties both registers and returns the parser to the index state.
//   While m_tready is low the result is held; one more byte is still accepted
//   into the input register, and s_tready then drops until the output drains.
`default_nettype none

module hpack_header_block_tokenizer_top
    import hpbt_pkg::*;
#(
    parameter int INT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] block_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] int_value
    output logic [5:0]       m_tuser,   // [2:0] element_kind, [4:3] representation,
                                        // [5] int_overflow
    output logic             m_tlast    // string_last
);

    logic                in_valid_reg;
    logic [7:0]          in_data_reg;
    logic                in_start_reg;
    ctrl_t               ctrl_reg;
    logic [INT_BITS-1:0] accum_reg;
    logic [INT_BITS-1:0] remaining_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic [31:0]         out_value_reg;

    logic                advance;
    ctrl_t               ctrl_cur;
    logic [INT_BITS-1:0] accum_cur;
    logic [INT_BITS-1:0] remaining_cur;
    ctrl_t               ctrl_next;
    logic [INT_BITS-1:0] accum_next;
    logic [INT_BITS-1:0] remaining_next;
    result_t             res_next;
    logic [INT_BITS-1:0] value_next;
    logic [63:0]         value_wide;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Block start handles the byte as if from the reset state.
    assign ctrl_cur      = in_start_reg ? CTRL_RESET : ctrl_reg;
    assign accum_cur     = in_start_reg ? '0 : accum_reg;
    assign remaining_cur = in_start_reg ? '0 : remaining_reg;

    hpbt_step #(
        .INT_BITS (INT_BITS)
    ) u_step (
        .data_byte      (in_data_reg),
        .ctrl_cur       (ctrl_cur),
        .accum_cur      (accum_cur),
        .remaining_cur  (remaining_cur),
        .ctrl_next      (ctrl_next),
        .accum_next     (accum_next),
        .remaining_next (remaining_next),
        .result         (res_next),
        .int_value      (value_next)
    );

    assign value_wide = 64'(value_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= CTRL_RESET;
            accum_reg     <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance)
            begin
                ctrl_reg      <= ctrl_next;
                accum_reg     <= accum_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (in_valid_reg && advance)
        begin
            out_res_reg   <= res_next;
            out_value_reg <= value_wide[31:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_res_reg.int_overflow, out_res_reg.representation,
                       out_res_reg.element_kind};
    assign m_tlast  = out_res_reg.string_last;

    // Only string bytes can close a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            (m_tuser[2:0] == KIND_KEY_BYTE || m_tuser[2:0] == KIND_VAL_BYTE))
        else $error("string end flagged on a non-string element");

    // Saturation is a property of integers, never of string bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[5]) |->
            (m_tuser[2:0] != KIND_KEY_BYTE && m_tuser[2:0] != KIND_VAL_BYTE))
        else $error("overflow flagged on a string byte");

    // The integer is reported only when an index or a length completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[2:0] == KIND_INT_PART || m_tuser[2:0] == KIND_KEY_BYTE
                      || m_tuser[2:0] == KIND_VAL_BYTE)) |-> (m_tdata == 32'd0))
        else $error("integer value present on a non-integer element");

    // Inside a string no integer may be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.parse_state == ST_KEY || ctrl_reg.parse_state == ST_VAL) |->
            (ctrl_reg.prefix_bits == PREFIX_NONE && !ctrl_reg.int_continues))
        else $error("integer state left open inside a string");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for hpack_header_block_tokenizer_top: drives header block bytes
// and predicts the classified token for each. Depends on hpbt_pkg and the tokenizer RTL.

module testbench
    import hpbt_pkg::*;
();

    localparam int          INT_BITS     = 32;
    localparam logic [63:0] SAT_MAX      = 64'h0000_0000_FFFF_FFFF;
    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 11;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          LONG_HOLD    = 60;
    localparam int          RANDOM_BYTES = 800;
    localparam int          QUIET_BYTES  = 150;
    localparam int          HOLD_AT      = 300;
    localparam int          PAUSE_AT     = 500;
    localparam int          CYCLE_LIMIT  = 400000;

    // First-byte patterns of the field representations.
    localparam logic [7:0] PAT_INDEXED       = 8'h80;
    localparam logic [7:0] PAT_INCREMENTAL   = 8'h40;
    localparam logic [7:0] PAT_SIZE_UPDATE   = 8'h20;
    localparam logic [7:0] PAT_NOT_INDEXED   = 8'h00;
    localparam logic [7:0] PAT_NEVER_INDEXED = 8'h10;

    typedef enum int {
        FORM_INDEXED,
        FORM_INCREMENTAL,
        FORM_SIZE_UPDATE,
        FORM_PLAIN
    } field_form_t;

    typedef struct packed {
        logic [2:0]  element_kind;
        logic [31:0] int_value;
        logic [1:0]  representation;
        logic        string_last;
        logic        int_overflow;
    } token_t;

    class token_tracker;
        token_t       expected_tokens[$];
        int           errors;
        parse_state_t phase;
        logic [2:0]   prefix_width;
        int unsigned  shift_amt;
        logic [63:0]  acc;
        logic [63:0]  str_left;
        bit           more;
        bit           saturated;
        logic [1:0]   rep;

        function new();
            errors = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase        = ST_IDX;
            prefix_width = PREFIX_NONE;
            shift_amt    = 0;
            acc          = '0;
            str_left     = '0;
            more         = 1'b0;
            saturated    = 1'b0;
            rep          = 2'd0;
        endfunction

        function logic [2:0] length_kind();
            if (phase == ST_KEY_LEN)
                return KIND_KEY_LEN;
            if (phase == ST_VAL_LEN)
                return KIND_VAL_LEN;
            return KIND_INDEX;
        endfunction

        function token_t classify_byte(logic [7:0] c, logic start);
            token_t      t;
            logic [63:0] chunk;
            logic [63:0] add;
            logic [63:0] mask;
            logic [2:0]  diff;
            bit          wide;
            bit          is_string;
            t = '0;
            if (start)
                clear_parser();
            if ((phase == ST_KEY || phase == ST_VAL) && str_left != 0)
            begin
                str_left = str_left - 1;
                t.element_kind = (phase == ST_KEY) ? KIND_KEY_BYTE : KIND_VAL_BYTE;
                t.string_last  = (str_left == 0);
            end
            else if (phase <= ST_VAL_LEN && more)
            begin
                // Continuation byte: 7 more bits, saturating once the sum no longer fits.
                chunk = {57'd0, c[6:0]};
                if (chunk != 0 && !saturated)
                begin
                    if (shift_amt >= INT_BITS || chunk > (SAT_MAX >> shift_amt))
                        saturated = 1'b1;
                    else
                    begin
                        add = chunk << shift_amt;
                        if (acc > SAT_MAX - add)
                            saturated = 1'b1;
                        else
                            acc = acc + add;
                    end
                end
                if (saturated)
                    acc = SAT_MAX;
                shift_amt      = (shift_amt + 7 > 63) ? 63 : shift_amt + 7;
                more           = c[7];
                t.int_overflow = saturated;
                if (!more)
                begin
                    t.element_kind = length_kind();
                    t.int_value    = acc[31:0];
                end
            end
            else
            begin
                wide      = (prefix_width == 3'd6 || prefix_width == 3'd4);
                is_string = 1'b0;
                if (phase == ST_KEY_LEN)
                begin
                    if (acc != 0)
                    begin
                        phase     = ST_KEY;
                        is_string = 1'b1;
                    end
                    else
                    begin
                        // An empty key goes straight on to the value length.
                        phase        = ST_VAL_LEN;
                        prefix_width = PREFIX_STRLEN;
                    end
                end
                else if (phase == ST_VAL_LEN && acc != 0)
                begin
                    phase     = ST_VAL;
                    is_string = 1'b1;
                end
                else if (phase == ST_IDX && wide && acc == 0)
                begin
                    phase        = ST_KEY_LEN;
                    prefix_width = PREFIX_STRLEN;
                end
                else if ((phase == ST_IDX && wide) || phase == ST_KEY)
                begin
                    phase        = ST_VAL_LEN;
                    prefix_width = PREFIX_STRLEN;
                end
                else
                begin
                    phase        = ST_IDX;
                    prefix_width = c[7] ? 3'd7 : c[6] ? 3'd6 : c[5] ? 3'd5 : 3'd4;
                    diff         = 3'd7 - prefix_width;
                    rep          = diff[1:0];
                end
                shift_amt = 0;
                more      = 1'b0;
                saturated = 1'b0;
                if (is_string)
                begin
                    str_left       = acc - 1;
                    prefix_width   = PREFIX_NONE;
                    acc            = '0;
                    t.element_kind = (phase == ST_KEY) ? KIND_KEY_BYTE : KIND_VAL_BYTE;
                    t.string_last  = (str_left == 0);
                end
                else
                begin
                    mask     = (64'd1 << prefix_width) - 64'd1;
                    acc      = {56'd0, c} & mask;
                    str_left = '0;
                    more     = (acc == mask);
                    if (!more)
                    begin
                        t.element_kind = length_kind();
                        t.int_value    = acc[31:0];
                    end
                end
            end
            t.representation = rep;
            return t;
        endfunction

        function void note_byte(logic [7:0] c, logic start);
            expected_tokens.push_back(classify_byte(c, start));
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (expected_tokens.size() == 0)
            begin
                $error("token with nothing pending: kind %0d, value %0d",
                       got.element_kind, got.int_value);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.element_kind !== want.element_kind)
            begin
                $error("element_kind: expected %0d, got %0d",
                       want.element_kind, got.element_kind);
                errors++;
            end
            if (got.int_value !== want.int_value)
            begin
                $error("int_value: expected %0d, got %0d", want.int_value, got.int_value);
                errors++;
            end
            if (got.representation !== want.representation)
            begin
                $error("representation: expected %0d, got %0d",
                       want.representation, got.representation);
                errors++;
            end
            if (got.string_last !== want.string_last)
            begin
                $error("string_last: expected %0d, got %0d", want.string_last, got.string_last);
                errors++;
            end
            if (got.int_overflow !== want.int_overflow)
            begin
                $error("int_overflow: expected %0d, got %0d",
                       want.int_overflow, got.int_overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    token_tracker board;
    bit           idle_on;
    bit           hold_req;
    int           byte_count;
    int           cycles;

    hpack_header_block_tokenizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] value, input logic start);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= value;
        s_tuser[0] <= start;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        board.note_byte(value, start);
        byte_count++;
        @(negedge clk);
    endtask

    // Stops offering bytes until every pending token has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_int(input int prefix_n, input logic [7:0] pattern,
                            input logic [63:0] value, input logic start);
        logic [63:0] mask;
        logic [63:0] rest;
        mask = (64'd1 << prefix_n) - 64'd1;
        if (value < mask)
            send_byte(pattern | value[7:0], start);
        else
        begin
            send_byte(pattern | mask[7:0], start);
            rest = value - mask;
            while (rest >= 128)
            begin
                send_byte({1'b1, rest[6:0]}, 1'b0);
                rest = rest >> 7;
            end
            send_byte({1'b0, rest[6:0]}, 1'b0);
        end
    endtask

    // A full prefix followed by random continuation bytes, often enough to saturate.
    task automatic send_long_int(input int prefix_n, input logic [7:0] pattern,
                                 input logic start);
        logic [7:0] mask;
        mask = 8'((1 << prefix_n) - 1);
        send_byte(pattern | mask, start);
        repeat ($urandom_range(0, 8))
            send_byte(8'($urandom_range(128, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 127)), 1'b0);
    endtask

    function automatic logic [63:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(100, 300);
        if (r < 4)
            return 0;
        return $urandom_range(1, 8);
    endfunction

    task automatic send_string(input logic [63:0] len);
        send_int(7, {1'($urandom_range(0, 1)), 7'd0}, len, 1'b0);
        repeat (len) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_field(input logic start);
        field_form_t form;
        logic [7:0]  pattern;
        int          prefix_n;
        bit          long_index;
        form       = field_form_t'($urandom_range(0, 3));
        long_index = ($urandom_range(0, 9) == 0);
        case (form)
            FORM_INDEXED:
            begin
                if (long_index)
                    send_long_int(7, PAT_INDEXED, start);
                else
                    send_int(7, PAT_INDEXED, $urandom_range(0, 70), start);
            end
            FORM_SIZE_UPDATE:
                send_int(5, PAT_SIZE_UPDATE, $urandom_range(0, 5000), start);
            default:
            begin
                if (form == FORM_INCREMENTAL)
                begin
                    prefix_n = 6;
                    pattern  = PAT_INCREMENTAL;
                end
                else
                begin
                    prefix_n = 4;
                    pattern  = $urandom_range(0, 1) ? PAT_NEVER_INDEXED : PAT_NOT_INDEXED;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    // New name: index zero, then the key string.
                    send_int(prefix_n, pattern, 0, start);
                    send_string(pick_len());
                end
                else if (long_index)
                    send_long_int(prefix_n, pattern, start);
                else if ($urandom_range(0, 19) == 0)
                    send_int(prefix_n, pattern, $urandom, start);
                else
                    send_int(prefix_n, pattern, $urandom_range(1, 70), start);
                send_string(pick_len());
            end
        endcase
    endtask

    task automatic send_opening();
        // First byte after reset is an indexed field; then the largest one-byte index.
        send_byte(8'h82, 1'b0);
        send_byte(8'hFE, 1'b0);
        // Incremental indexing with a new name: empty key, one Huffman-flagged value byte.
        send_byte(8'h40, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0); send_byte(8'hAB, 1'b0);
        // Not indexed, name index 15 + 2 over a continuation byte, empty value.
        send_byte(8'h0F, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h00, 1'b0);
        // Never indexed with a new name; the value string is cut short below.
        send_byte(8'h10, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h61, 1'b0);
        send_byte(8'h02, 1'b0); send_byte(8'h78, 1'b0);
        // Block start in the middle of a string, then an index that saturates.
        send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h0F, 1'b0);
        // Table size update with two continuation bytes.
        send_byte(8'h3F, 1'b0); send_byte(8'hE1, 1'b0); send_byte(8'h1F, 1'b0);
    endtask

    task automatic send_random_fields();
        int stop_at;
        bit next_start;
        bit hold_done;
        bit pause_done;
        stop_at    = byte_count + RANDOM_BYTES;
        next_start = 1'b1;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (byte_count < stop_at)
        begin
            if (byte_count >= stop_at - QUIET_BYTES)
                idle_on = 1'b0;
            if (!hold_done && byte_count >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && byte_count >= PAUSE_AT)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 8)
            begin
                // Noise can leave the parser anywhere, so a block start follows it.
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                next_start = 1'b1;
            end
            else
            begin
                send_field(next_start || $urandom_range(0, 19) == 0);
                next_start = 1'b0;
            end
        end
    endtask

    initial
    begin
        board      = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        byte_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_opening();
        wait_drained();
        send_random_fields();
        wait_drained();
        if (board.errors == 0 && board.expected_tokens.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        int unsigned gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // Long hold-off: the tokenizer fills up and must stall its input.
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 17);
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin : monitor
        token_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                got.element_kind   = m_tuser[2:0];
                got.representation = m_tuser[4:3];
                got.int_overflow   = m_tuser[5];
                got.int_value      = m_tdata;
                got.string_last    = m_tlast;
                board.check_token(got);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
rtl/hpbt_pkg.sv
rtl/hpbt_step.sv
rtl/hpack_header_block_tokenizer_top.sv
tb/testbench.sv
